[sv/gpm_pkg.sv]
// Package for the glob pattern matcher: sizes, op and token codes, beat types
// and the star-closure function. No dependencies.
package gpm_pkg;

    localparam int MAX_TOKENS = 16;
    localparam int NPOS       = MAX_TOKENS + 1;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

    localparam logic [CNT_W-1:0] TOKEN_LIMIT = CNT_W'(MAX_TOKENS);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_STRING = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_ANY     = 2'd1;
    localparam logic [1:0] KIND_STAR    = 2'd2;

    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef logic [NPOS-1:0] pos_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
    } beat_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } result_t;

    // Every live star position makes the following positions live through a run of
    // stars; the carries of s + (v & s) are exactly that run fill.
    function automatic pos_t closure(pos_t v, pos_t s);
        pos_t g;
        g = v & s;
        return v | (s ^ g ^ (s + g));
    endfunction

endpackage

[sv/glob_pattern_matcher.sv]
// Glob pattern matcher top level: stream ports, input beat register and
// two-entry result buffer. Depends on gpm_pkg and gpm_match_core.
//
// Usage: every input beat carries an op in s_tuser and a byte in s_tdata.
// Op clear empties the pattern, op append adds one pattern byte (star, question
// mark, backslash escape), op string feeds one string byte, op end closes the
// string and produces one result beat: m_tdata[0] matched, m_tuser[0] set when
// the pattern overflowed the 16-entry token store (matched is then 0).
// Only end beats produce output; all other ops are absorbed silently.
// Result path: an end beat is taken into the input register, and its result is
// then written into the result buffer, whose head entry drives m_tvalid.
// Throughput: one beat per cycle while s_tready is high; each beat is resolved
// in one pass of the active-position update from input register to result buffer.
// Stall: the result buffer holds two results, so a beat keeps being accepted
// while one result waits; s_tready drops only when an end beat waits in the
// input register with both entries full; other beats keep flowing until then.
// Reset: clears the pattern, the string state and both result entries.
module glob_pattern_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [1:0] s_tuser,   // [1:0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] matched, [7:1] zero
    output logic       m_tuser    // [0] pattern_overflow
);

    logic             in_valid_reg;
    gpm_pkg::beat_t   in_beat_reg;
    logic             advance;
    logic             push;
    logic             pop;
    gpm_pkg::result_t core_result;

    logic             out_valid_reg;
    gpm_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    gpm_pkg::result_t skid_data_reg;

    assign advance  = in_valid_reg
                   && ((in_beat_reg.op != gpm_pkg::OP_END) || !skid_valid_reg);
    assign push     = advance && (in_beat_reg.op == gpm_pkg::OP_END);
    assign pop      = out_valid_reg && m_tready;
    assign s_tready = !in_valid_reg || advance;

    gpm_match_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .beat   (in_beat_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_beat_reg.op         <= s_tuser;
            in_beat_reg.byte_value <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= core_result;
            else
                out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg.matched};
    assign m_tuser  = out_data_reg.pattern_overflow;

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without head entry");

    a_plain_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_beat_reg.op != gpm_pkg::OP_END) |-> s_tready)
        else $error("non-result beat stalled");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pop) |=> skid_valid_reg)
        else $error("buffered result dropped");
`endif

endmodule

[sv/gpm_match_core.sv]
// Glob matcher core: token store, escape/overflow control and the active
// position vector. Depends on gpm_pkg.
module gpm_match_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  gpm_pkg::beat_t  beat,
    output gpm_pkg::result_t result
);

    logic [1:0]                kind_reg [gpm_pkg::MAX_TOKENS];
    logic [7:0]                char_reg [gpm_pkg::MAX_TOKENS];
    logic [gpm_pkg::CNT_W-1:0] token_count_reg, token_count_next;
    logic                      escape_pending_reg, escape_pending_next;
    logic                      overflow_reg, overflow_next;
    logic                      string_started_reg, string_started_next;
    gpm_pkg::pos_t             active_reg, active_next;

    logic [gpm_pkg::MAX_TOKENS-1:0] in_pat;
    logic [gpm_pkg::MAX_TOKENS-1:0] step_ok;
    gpm_pkg::pos_t                  star_pos;
    gpm_pkg::pos_t                  esc_pos;
    gpm_pkg::pos_t                  star_push;
    gpm_pkg::pos_t                  advanced;
    logic                           full;
    logic                           is_bs;
    logic                           pat_open;
    logic                           push_req;
    logic [1:0]                     push_kind;
    logic [gpm_pkg::CNT_W-1:0]      eff_len;

    always_comb
    begin
        star_pos = '0;
        for (int i = 0; i < gpm_pkg::MAX_TOKENS; i++)
        begin
            in_pat[i]   = token_count_reg > gpm_pkg::CNT_W'(i);
            star_pos[i] = in_pat[i] && (kind_reg[i] == gpm_pkg::KIND_STAR);
        end
    end

    assign esc_pos = escape_pending_reg ? (gpm_pkg::pos_t'(1) << token_count_reg) : '0;
    assign is_bs   = beat.byte_value == gpm_pkg::CH_BACKSLASH;

    always_comb
    begin
        for (int i = 0; i < gpm_pkg::MAX_TOKENS; i++)
        begin
            step_ok[i] = (in_pat[i] && (kind_reg[i] == gpm_pkg::KIND_ANY))
                      || (in_pat[i] && (kind_reg[i] == gpm_pkg::KIND_LITERAL)
                          && (char_reg[i] == beat.byte_value))
                      || (esc_pos[i] && is_bs);
        end
    end

    // star positions stay live, matching positions move one ahead
    assign advanced = (active_reg & star_pos)
                    | {active_reg[gpm_pkg::MAX_TOKENS-1:0] & step_ok, 1'b0};

    assign full     = token_count_reg == gpm_pkg::TOKEN_LIMIT;
    assign pat_open = !string_started_reg && !overflow_reg;
    assign push_req = (beat.op == gpm_pkg::OP_APPEND) && pat_open
                   && (escape_pending_reg || !is_bs);

    always_comb
    begin
        if (escape_pending_reg)
            push_kind = gpm_pkg::KIND_LITERAL;
        else if (beat.byte_value == gpm_pkg::CH_STAR)
            push_kind = gpm_pkg::KIND_STAR;
        else if (beat.byte_value == gpm_pkg::CH_QUESTION)
            push_kind = gpm_pkg::KIND_ANY;
        else
            push_kind = gpm_pkg::KIND_LITERAL;
    end

    assign star_push = star_pos | ((push_kind == gpm_pkg::KIND_STAR)
                     ? (gpm_pkg::pos_t'(1) << token_count_reg) : '0);

    always_comb
    begin
        token_count_next    = token_count_reg;
        escape_pending_next = escape_pending_reg;
        overflow_next       = overflow_reg;
        string_started_next = string_started_reg;
        active_next         = active_reg;
        if (fire)
        begin
            unique case (beat.op)
                gpm_pkg::OP_CLEAR:
                begin
                    token_count_next    = '0;
                    escape_pending_next = 1'b0;
                    overflow_next       = 1'b0;
                    string_started_next = 1'b0;
                    active_next         = gpm_pkg::pos_t'(1);
                end
                gpm_pkg::OP_APPEND:
                begin
                    if (push_req)
                    begin
                        escape_pending_next = 1'b0;
                        if (full)
                            overflow_next = 1'b1;
                        else
                        begin
                            token_count_next = token_count_reg + gpm_pkg::CNT_W'(1);
                            active_next      = gpm_pkg::closure(gpm_pkg::pos_t'(1), star_push);
                        end
                    end
                    else if (pat_open)
                    begin
                        if (full)
                            overflow_next = 1'b1;
                        else
                            escape_pending_next = 1'b1;
                    end
                end
                gpm_pkg::OP_STRING:
                begin
                    string_started_next = 1'b1;
                    active_next         = gpm_pkg::closure(advanced, star_pos);
                end
                gpm_pkg::OP_END:
                begin
                    string_started_next = 1'b0;
                    active_next         = gpm_pkg::closure(gpm_pkg::pos_t'(1), star_pos);
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_count_reg    <= '0;
            escape_pending_reg <= 1'b0;
            overflow_reg       <= 1'b0;
            string_started_reg <= 1'b0;
            active_reg         <= gpm_pkg::pos_t'(1);
        end
        else
        begin
            token_count_reg    <= token_count_next;
            escape_pending_reg <= escape_pending_next;
            overflow_reg       <= overflow_next;
            string_started_reg <= string_started_next;
            active_reg         <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && push_req && !full)
        begin
            kind_reg[token_count_reg[gpm_pkg::IDX_W-1:0]] <= push_kind;
            char_reg[token_count_reg[gpm_pkg::IDX_W-1:0]] <= beat.byte_value;
        end
    end

    assign eff_len = token_count_reg + gpm_pkg::CNT_W'(escape_pending_reg);

    assign result.matched          = active_reg[eff_len] && !overflow_reg;
    assign result.pattern_overflow = overflow_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        token_count_reg <= gpm_pkg::TOKEN_LIMIT)
        else $error("token count beyond capacity");

    a_escape_room: assert property (@(posedge clk) disable iff (!rst_n)
        escape_pending_reg |-> (token_count_reg < gpm_pkg::TOKEN_LIMIT))
        else $error("pending escape with full store");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && beat.op == gpm_pkg::OP_CLEAR) |=>
        (token_count_reg == '0 && active_reg == gpm_pkg::pos_t'(1) && !overflow_reg))
        else $error("clear left pattern state");

    a_ovf_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflow_reg) |-> $past(fire && beat.op == gpm_pkg::OP_APPEND))
        else $error("overflow set outside pattern load");
`endif

endmodule
